>>> rtl/fdab_pkg.sv
`default_nettype none

package fdab_pkg;

   typedef enum logic [4:0] {
      PH_SIG,
      PH_SKIP,
      PH_PREV,
      PH_TAG,
      PH_DROP,
      PH_VHDR,
      PH_VPKT,
      PH_VCT,
      PH_CFG,
      PH_SPSLEN,
      PH_SPSDAT,
      PH_PPSNUM,
      PH_PPSLEN,
      PH_PPSDAT,
      PH_NALLEN,
      PH_NALDAT,
      PH_AHDR,
      PH_APKT,
      PH_ADAT,
      PH_DEAD
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  unit_kind;
      logic [31:0] unit_time;
      logic [3:0]  frame_kind;
      logic        audio_channels;
      logic        audio_wide;
      logic        end_of_unit;
      logic        bad_header;
   } rsp_payload_type;

   localparam logic [1:0] KIND_AVC_CONFIG = 2'd0;
   localparam logic [1:0] KIND_AVC_NALU   = 2'd1;
   localparam logic [1:0] KIND_AAC_CONFIG = 2'd2;
   localparam logic [1:0] KIND_AAC_RAW    = 2'd3;

   localparam logic CSR_PASS_AUDIO = 1'b0;
   localparam logic CSR_PASS_VIDEO = 1'b1;

   localparam logic [7:0] TAG_AUDIO  = 8'h08;
   localparam logic [7:0] TAG_VIDEO  = 8'h09;
   localparam logic [3:0] CODEC_AVC  = 4'd7;
   localparam logic [3:0] FORMAT_AAC = 4'd10;
   localparam logic [7:0] PKT_CONFIG = 8'h00;
   localparam logic [7:0] PKT_NALU   = 8'h01;

   localparam logic [31:0] FILE_HDR_LEN = 32'd9;
   localparam logic [31:0] TAG_HDR_LEN  = 32'd11;
   localparam logic [31:0] PREV_LEN     = 32'd4;
   localparam logic [31:0] VCT_LEN      = 32'd3;
   localparam logic [31:0] CFG_LEN      = 32'd6;

   localparam int MAX_RESULTS = 4;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_AW     = 3;
   localparam int FIFO_CW     = 4;

   function automatic logic [7:0] sig_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h46;
         2'd1:    val = 8'h4C;
         2'd2:    val = 8'h56;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

>>> rtl/fdab_if.sv
`default_nettype none

interface fdab_req_if;
   import fdab_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fdab_rsp_if;
   import fdab_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/flv_demux_to_annexb_core.sv
// Each result is queued by its input transaction and shows on rsp_chan once the
// results ahead of it have left. One input byte per cycle while req_chan.ready;
// each input yields 0, 1 or 4 results, which leave an 8-entry result queue at one
// per cycle while rsp_chan.ready. Input stalls while over 4 results are queued.
// Reset (synchronous, active high) clears parse state and the queue and sets
// pass_audio and pass_video to 1.
`default_nettype none

module flv_demux_to_annexb_core (
   input  logic        clock,
   input  logic        reset,
   fdab_req_if.sink    req_chan,
   fdab_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import fdab_pkg::*;

   logic pass_audio_ff;
   logic pass_video_ff;

   phase_type   phase_ff, phase_in;
   logic [31:0] field_count_ff, field_count_in;
   logic [23:0] tag_remaining_ff, tag_remaining_in;
   logic [31:0] nal_remaining_ff, nal_remaining_in;
   logic [2:0]  length_bytes_ff, length_bytes_in;
   logic [7:0]  set_count_ff, set_count_in;
   logic [7:0]  tag_kind_ff, tag_kind_in;
   logic [31:0] tag_time_ff, tag_time_in;
   logic [7:0]  media_flags_ff, media_flags_in;

   rsp_payload_type      fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CW-1:0]   count_ff;

   logic [7:0]  b;
   logic        req_fire;
   logic        pop;
   logic [31:0] fc_inc;
   logic [31:0] fc_dec;
   logic [31:0] nal_dec;
   logic [31:0] nal16;
   logic [31:0] nal32;
   logic [31:0] sig_len;
   logic [23:0] tag_rem_dec;
   logic        tag_end;
   logic        tail_phase;
   logic        sig_bad;
   logic        pps;
   logic [7:0]  sc_dec;

   logic [2:0]  emit_n;
   logic [2:0]  push_n;
   logic [1:0]  emit_kind;
   logic [7:0]  emit_byte;
   logic        emit_eou;
   logic        emit_bad;
   rsp_payload_type emit_entry [MAX_RESULTS];

   // configuration
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_audio_ff <= 1'b1;
         pass_video_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_paddr[2])
            CSR_PASS_AUDIO: pass_audio_ff <= csr_pwdata[0];
            CSR_PASS_VIDEO: pass_video_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_PASS_AUDIO: csr_prdata = {31'd0, pass_audio_ff};
         CSR_PASS_VIDEO: csr_prdata = {31'd0, pass_video_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // handshake
   assign b              = req_chan.payload.in_byte;
   assign req_chan.ready = count_ff <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = count_ff != '0;
   assign rsp_chan.payload = fifo_ff[rd_ptr_ff];
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   // shared datapath terms
   assign fc_inc      = field_count_ff + 32'd1;
   assign fc_dec      = field_count_ff - 32'd1;
   assign nal_dec     = nal_remaining_ff - 32'd1;
   assign nal16       = {16'd0, nal_remaining_ff[7:0], b};
   assign nal32       = {nal_remaining_ff[23:0], b};
   assign sig_len     = (field_count_ff >= 32'd5) ? nal32 : nal_remaining_ff;
   assign tag_rem_dec = (tag_remaining_ff != '0) ? tag_remaining_ff - 24'd1 : 24'd0;
   assign tag_end     = tag_rem_dec == '0;
   assign sig_bad     = (field_count_ff < 32'd3) && (b != sig_byte(field_count_ff[1:0]));
   assign pps         = (phase_ff == PH_PPSLEN) || (phase_ff == PH_PPSDAT);
   assign sc_dec      = set_count_ff - 8'd1;

   always_comb begin
      tail_phase = !(phase_ff inside {PH_SIG, PH_SKIP, PH_PREV, PH_TAG, PH_DEAD});
   end

   // next state
   always_comb begin
      phase_in         = phase_ff;
      field_count_in   = field_count_ff;
      tag_remaining_in = tag_remaining_ff;
      nal_remaining_in = nal_remaining_ff;
      length_bytes_in  = length_bytes_ff;
      set_count_in     = set_count_ff;
      tag_kind_in      = tag_kind_ff;
      tag_time_in      = tag_time_ff;
      media_flags_in   = media_flags_ff;

      if (req_fire) begin
         case (phase_ff)
            PH_SIG: begin
               if (sig_bad) begin
                  phase_in = PH_DEAD;
               end else begin
                  nal_remaining_in = sig_len;
                  field_count_in   = fc_inc;
                  if (fc_inc == FILE_HDR_LEN) begin
                     field_count_in   = (sig_len > FILE_HDR_LEN) ? sig_len - FILE_HDR_LEN
                                                                 : 32'd0;
                     nal_remaining_in = '0;
                     phase_in = (sig_len > FILE_HDR_LEN) ? PH_SKIP : PH_PREV;
                  end
               end
            end
            PH_SKIP: begin
               field_count_in = fc_dec;
               if (fc_dec == '0) begin
                  phase_in = PH_PREV;
               end
            end
            PH_PREV: begin
               field_count_in = fc_inc;
               if (fc_inc >= PREV_LEN) begin
                  field_count_in = '0;
                  phase_in       = PH_TAG;
               end
            end
            PH_TAG: begin
               if (field_count_ff == 32'd0) begin
                  tag_kind_in = b;
               end else if (field_count_ff <= 32'd3) begin
                  tag_remaining_in = {tag_remaining_ff[15:0], b};
               end else if (field_count_ff <= 32'd6) begin
                  tag_time_in = {8'd0, tag_time_ff[15:0], b};
               end else if (field_count_ff == 32'd7) begin
                  tag_time_in = tag_time_ff | {b, 24'd0};
               end
               field_count_in = fc_inc;
               if (fc_inc >= TAG_HDR_LEN) begin
                  field_count_in = '0;
                  if (tag_remaining_in == '0) begin
                     phase_in = PH_PREV;
                  end else if (tag_kind_in == TAG_AUDIO) begin
                     phase_in = PH_AHDR;
                  end else if (tag_kind_in == TAG_VIDEO) begin
                     phase_in = PH_VHDR;
                  end else begin
                     phase_in = PH_DROP;
                  end
               end
            end
            PH_VHDR: begin
               media_flags_in = b;
               phase_in = (b[3:0] == CODEC_AVC) ? PH_VPKT : PH_DROP;
            end
            PH_VPKT: begin
               nal_remaining_in = {24'd0, b};
               field_count_in   = '0;
               phase_in         = PH_VCT;
            end
            PH_VCT: begin
               field_count_in = fc_inc;
               if (fc_inc >= VCT_LEN) begin
                  field_count_in = '0;
                  if (nal_remaining_ff == {24'd0, PKT_CONFIG}) begin
                     phase_in = PH_CFG;
                  end else if (nal_remaining_ff == {24'd0, PKT_NALU}) begin
                     phase_in = PH_NALLEN;
                  end else begin
                     phase_in = PH_DROP;
                  end
                  nal_remaining_in = '0;
               end
            end
            PH_CFG: begin
               if (field_count_ff == 32'd4) begin
                  length_bytes_in = {1'b0, b[1:0]} + 3'd1;
               end
               field_count_in = fc_inc;
               if (fc_inc >= CFG_LEN) begin
                  set_count_in     = {3'd0, b[4:0]};
                  field_count_in   = '0;
                  nal_remaining_in = '0;
                  phase_in = (b[4:0] != '0) ? PH_SPSLEN : PH_PPSNUM;
               end
            end
            PH_SPSLEN, PH_PPSLEN: begin
               nal_remaining_in = nal16;
               field_count_in   = fc_inc;
               if (fc_inc >= 32'd2) begin
                  if (nal16 == '0) begin
                     set_count_in     = sc_dec;
                     field_count_in   = '0;
                     nal_remaining_in = '0;
                     if (sc_dec == '0) begin
                        phase_in = pps ? PH_DROP : PH_PPSNUM;
                     end else begin
                        phase_in = pps ? PH_PPSLEN : PH_SPSLEN;
                     end
                  end else begin
                     phase_in = pps ? PH_PPSDAT : PH_SPSDAT;
                  end
               end
            end
            PH_SPSDAT, PH_PPSDAT: begin
               nal_remaining_in = nal_dec;
               if (nal_dec == '0) begin
                  set_count_in     = sc_dec;
                  field_count_in   = '0;
                  nal_remaining_in = '0;
                  if (sc_dec == '0) begin
                     phase_in = pps ? PH_DROP : PH_PPSNUM;
                  end else begin
                     phase_in = pps ? PH_PPSLEN : PH_SPSLEN;
                  end
               end
            end
            PH_PPSNUM: begin
               set_count_in     = b;
               field_count_in   = '0;
               nal_remaining_in = '0;
               phase_in = (b != '0) ? PH_PPSLEN : PH_DROP;
            end
            PH_NALLEN: begin
               nal_remaining_in = nal32;
               field_count_in   = fc_inc;
               if (fc_inc >= {29'd0, length_bytes_ff}) begin
                  field_count_in = '0;
                  phase_in = (nal32 != '0) ? PH_NALDAT : PH_NALLEN;
               end
            end
            PH_NALDAT: begin
               nal_remaining_in = nal_dec;
               if (nal_dec == '0) begin
                  field_count_in = '0;
                  phase_in       = PH_NALLEN;
               end
            end
            PH_AHDR: begin
               media_flags_in = b;
               phase_in = (b[7:4] == FORMAT_AAC) ? PH_APKT : PH_DROP;
            end
            PH_APKT: begin
               if (b <= 8'd1) begin
                  nal_remaining_in = 32'd2 + {24'd0, b};
                  phase_in         = PH_ADAT;
               end else begin
                  phase_in = PH_DROP;
               end
            end
            default: ;
         endcase

         // each payload byte counts down the tag
         if (tail_phase) begin
            tag_remaining_in = tag_rem_dec;
            if (tag_end) begin
               field_count_in   = '0;
               nal_remaining_in = '0;
               phase_in         = PH_PREV;
            end
         end
      end
   end

   // results of the current byte
   always_comb begin
      emit_n    = 3'd0;
      emit_kind = KIND_AVC_CONFIG;
      emit_byte = b;
      emit_eou  = 1'b0;
      emit_bad  = 1'b0;

      case (phase_ff)
         PH_SIG: begin
            if (sig_bad) begin
               emit_n   = 3'd1;
               emit_bad = 1'b1;
            end
         end
         PH_SPSLEN, PH_PPSLEN: begin
            if (fc_inc >= 32'd2) begin
               emit_n    = 3'd4;
               emit_kind = KIND_AVC_CONFIG;
               emit_eou  = nal16 == '0;
            end
         end
         PH_SPSDAT, PH_PPSDAT: begin
            emit_n    = 3'd1;
            emit_kind = KIND_AVC_CONFIG;
            emit_eou  = nal_dec == '0;
         end
         PH_NALLEN: begin
            if (fc_inc >= {29'd0, length_bytes_ff}) begin
               emit_n    = 3'd4;
               emit_kind = KIND_AVC_NALU;
               emit_eou  = nal32 == '0;
            end
         end
         PH_NALDAT: begin
            emit_n    = 3'd1;
            emit_kind = KIND_AVC_NALU;
            emit_eou  = nal_dec == '0;
         end
         PH_ADAT: begin
            emit_n    = 3'd1;
            emit_kind = nal_remaining_ff[1:0];
            emit_eou  = tag_remaining_ff == 24'd1;
         end
         default: ;
      endcase

      if (!emit_bad && (emit_kind[1] ? !pass_audio_ff : !pass_video_ff)) begin
         emit_n = 3'd0;
      end
      if (tail_phase && tag_end) begin
         emit_eou = 1'b1;
      end

      for (int k = 0; k < MAX_RESULTS; k++) begin
         emit_entry[k].out_byte       = (emit_n == 3'd1) ? emit_byte
                                                         : {7'd0, k == MAX_RESULTS - 1};
         emit_entry[k].unit_kind      = emit_bad ? 2'd0 : emit_kind;
         emit_entry[k].unit_time      = emit_bad ? 32'd0 : tag_time_ff;
         emit_entry[k].frame_kind     = (emit_bad || emit_kind[1]) ? 4'd0
                                                                   : media_flags_ff[7:4];
         emit_entry[k].audio_channels = !emit_bad && emit_kind[1] && media_flags_ff[0];
         emit_entry[k].audio_wide     = !emit_bad && emit_kind[1] && media_flags_ff[1];
         emit_entry[k].end_of_unit    = !emit_bad && emit_eou && (3'(k) == emit_n - 3'd1);
         emit_entry[k].bad_header     = emit_bad;
         if (emit_bad) begin
            emit_entry[k].out_byte = 8'd0;
         end
      end
   end

   assign push_n = req_fire ? emit_n : 3'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_SIG;
         field_count_ff   <= '0;
         tag_remaining_ff <= '0;
         nal_remaining_ff <= '0;
         length_bytes_ff  <= 3'd4;
         set_count_ff     <= '0;
         tag_kind_ff      <= '0;
         tag_time_ff      <= '0;
         media_flags_ff   <= '0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         count_ff         <= '0;
      end else begin
         phase_ff         <= phase_in;
         field_count_ff   <= field_count_in;
         tag_remaining_ff <= tag_remaining_in;
         nal_remaining_ff <= nal_remaining_in;
         length_bytes_ff  <= length_bytes_in;
         set_count_ff     <= set_count_in;
         tag_kind_ff      <= tag_kind_in;
         tag_time_ff      <= tag_time_in;
         media_flags_ff   <= media_flags_in;
         wr_ptr_ff        <= wr_ptr_ff + FIFO_AW'(push_n);
         rd_ptr_ff        <= rd_ptr_ff + FIFO_AW'(pop);
         count_ff         <= count_ff + FIFO_CW'(push_n) - FIFO_CW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (3'(k) < push_n) begin
            fifo_ff[wr_ptr_ff + FIFO_AW'(k)] <= emit_entry[k];
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CW'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_ptr_track : assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[FIFO_AW-1:0])
      else $error("queue pointers disagree with count");

   a_dead_sticks : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DEAD |=> phase_ff == PH_DEAD)
      else $error("parser left dead phase");

   a_len_range : assert property (@(posedge clock) disable iff (reset)
      length_bytes_ff >= 3'd1 && length_bytes_ff <= 3'd4)
      else $error("NAL length size out of range");

   a_nal_len_idle : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_NALLEN) |-> field_count_ff < {29'd0, length_bytes_ff})
      else $error("length prefix count overran");
`endif

endmodule

`default_nettype wire

>>> bench/tb_flv_demux_to_annexb_core.sv
`default_nettype none

module tb_flv_demux_to_annexb_core;
   timeunit 1ns;
   timeprecision 1ps;

   import fdab_pkg::*;

   localparam logic [23:0] FLV_SIG   = 24'h464C56;
   localparam logic [7:0]  TAG_META  = 8'h12;
   localparam int          SIDE_SEND = 0;
   localparam int          SIDE_RECV = 1;
   localparam logic [4:0]  AUDIO_PLAN = 5'b10101;
   localparam logic [4:0]  VIDEO_PLAN = 5'b10011;

   class annexb_scoreboard;
      rsp_payload_type es_expected[$];
      rsp_payload_type step_out[$];
      int errors;
      logic pass_audio, pass_video;
      phase_type phase;
      logic [31:0] field_count, nal_remaining, tag_time;
      logic [23:0] tag_remaining;
      logic [2:0] length_bytes;
      logic [7:0] set_count, tag_kind, media_flags;
      logic header_ok;

      function new();
         errors = 0;
         pass_audio = 1'b1;
         pass_video = 1'b1;
         phase = PH_SIG;
         field_count = '0;
         nal_remaining = '0;
         tag_time = '0;
         tag_remaining = '0;
         length_bytes = 3'd4;
         set_count = '0;
         tag_kind = '0;
         media_flags = '0;
         header_ok = 1'b0;
      endfunction

      function void fail(string what);
         errors++;
         if (errors <= 10)
            $display("mismatch %0d at %0t: %s", errors, $time, what);
      endfunction

      function void set_pass(logic idx, logic val);
         if (idx == CSR_PASS_AUDIO)
            pass_audio = val;
         else
            pass_video = val;
      endfunction

      function void emit(logic [7:0] b, logic [1:0] kind, logic eou);
         rsp_payload_type r;
         logic audio;
         audio = kind >= KIND_AAC_CONFIG;
         if (audio ? !pass_audio : !pass_video)
            return;
         r = '0;
         r.out_byte = b;
         r.unit_kind = kind;
         r.unit_time = tag_time;
         r.frame_kind = audio ? 4'd0 : media_flags[7:4];
         r.audio_channels = audio ? media_flags[0] : 1'b0;
         r.audio_wide = audio ? media_flags[1] : 1'b0;
         r.end_of_unit = eou;
         step_out.push_back(r);
      endfunction

      function void start_code(logic [1:0] kind, logic eou);
         emit(8'h00, kind, 1'b0);
         emit(8'h00, kind, 1'b0);
         emit(8'h00, kind, 1'b0);
         emit(8'h01, kind, eou);
      endfunction

      function void set_done(logic pps);
         set_count = set_count - 8'd1;
         field_count = '0;
         nal_remaining = '0;
         if (set_count == 0)
            phase = pps ? PH_DROP : PH_PPSNUM;
         else
            phase = pps ? PH_PPSLEN : PH_SPSLEN;
      endfunction

      function void note_flv_byte(logic [7:0] b);
         rsp_payload_type r;
         logic [7:0] sig_b;
         logic pps;
         step_out.delete();
         case (phase)
            PH_DEAD: return;
            PH_SIG: begin
               if (field_count < 3) begin
                  sig_b = FLV_SIG[8 * (2 - field_count) +: 8];
                  if (b != sig_b) begin
                     r = '0;
                     r.bad_header = 1'b1;
                     es_expected.push_back(r);
                     header_ok = 1'b0;
                     phase = PH_DEAD;
                     return;
                  end
               end
               if (field_count == 2)
                  header_ok = 1'b1;
               if (field_count >= 5)
                  nal_remaining = {nal_remaining[23:0], b};
               field_count++;
               if (field_count == 9) begin
                  field_count = (nal_remaining > 9) ? nal_remaining - 32'd9 : 32'd0;
                  nal_remaining = '0;
                  phase = (field_count != 0) ? PH_SKIP : PH_PREV;
               end
               return;
            end
            PH_SKIP: begin
               field_count--;
               if (field_count == 0)
                  phase = PH_PREV;
               return;
            end
            PH_PREV: begin
               field_count++;
               if (field_count >= 4) begin
                  field_count = '0;
                  phase = PH_TAG;
               end
               return;
            end
            PH_TAG: begin
               if (field_count == 0)
                  tag_kind = b;
               else if (field_count <= 3)
                  tag_remaining = {tag_remaining[15:0], b};
               else if (field_count <= 6)
                  tag_time = {8'h00, tag_time[15:0], b};
               else if (field_count == 7)
                  tag_time = tag_time | {b, 24'h000000};
               field_count++;
               if (field_count >= 11) begin
                  field_count = '0;
                  if (tag_remaining == 0)
                     phase = PH_PREV;
                  else if (tag_kind == TAG_AUDIO)
                     phase = PH_AHDR;
                  else if (tag_kind == TAG_VIDEO)
                     phase = PH_VHDR;
                  else
                     phase = PH_DROP;
               end
               return;
            end
            PH_VHDR: begin
               media_flags = b;
               phase = (b[3:0] == CODEC_AVC) ? PH_VPKT : PH_DROP;
            end
            PH_VPKT: begin
               nal_remaining = {24'h0, b};
               field_count = '0;
               phase = PH_VCT;
            end
            PH_VCT: begin
               field_count++;
               if (field_count >= 3) begin
                  field_count = '0;
                  if (nal_remaining == PKT_CONFIG)
                     phase = PH_CFG;
                  else if (nal_remaining == PKT_NALU)
                     phase = PH_NALLEN;
                  else
                     phase = PH_DROP;
                  nal_remaining = '0;
               end
            end
            PH_CFG: begin
               if (field_count == 4)
                  length_bytes = {1'b0, b[1:0]} + 3'd1;
               field_count++;
               if (field_count >= 6) begin
                  set_count = {3'b000, b[4:0]};
                  field_count = '0;
                  nal_remaining = '0;
                  phase = (set_count != 0) ? PH_SPSLEN : PH_PPSNUM;
               end
            end
            PH_SPSLEN, PH_PPSLEN: begin
               pps = (phase == PH_PPSLEN);
               nal_remaining = {16'h0, nal_remaining[7:0], b};
               field_count++;
               if (field_count >= 2) begin
                  start_code(KIND_AVC_CONFIG, nal_remaining == 0);
                  if (nal_remaining == 0)
                     set_done(pps);
                  else
                     phase = pps ? PH_PPSDAT : PH_SPSDAT;
               end
            end
            PH_SPSDAT, PH_PPSDAT: begin
               pps = (phase == PH_PPSDAT);
               nal_remaining--;
               emit(b, KIND_AVC_CONFIG, nal_remaining == 0);
               if (nal_remaining == 0)
                  set_done(pps);
            end
            PH_PPSNUM: begin
               set_count = b;
               field_count = '0;
               nal_remaining = '0;
               phase = (set_count != 0) ? PH_PPSLEN : PH_DROP;
            end
            PH_NALLEN: begin
               nal_remaining = {nal_remaining[23:0], b};
               field_count++;
               if (field_count >= length_bytes) begin
                  start_code(KIND_AVC_NALU, nal_remaining == 0);
                  field_count = '0;
                  phase = (nal_remaining != 0) ? PH_NALDAT : PH_NALLEN;
               end
            end
            PH_NALDAT: begin
               nal_remaining--;
               emit(b, KIND_AVC_NALU, nal_remaining == 0);
               if (nal_remaining == 0) begin
                  field_count = '0;
                  phase = PH_NALLEN;
               end
            end
            PH_AHDR: begin
               media_flags = b;
               phase = (b[7:4] == FORMAT_AAC) ? PH_APKT : PH_DROP;
            end
            PH_APKT: begin
               if (b <= 8'd1) begin
                  nal_remaining = 32'd2 + b;
                  phase = PH_ADAT;
               end else begin
                  phase = PH_DROP;
               end
            end
            PH_ADAT: emit(b, nal_remaining[1:0], tag_remaining == 1);
            default: ;
         endcase

         // payload byte consumed; tag size wins over any unit in progress
         if (tag_remaining > 0)
            tag_remaining--;
         if (tag_remaining == 0) begin
            if (step_out.size() > 0) begin
               r = step_out.pop_back();
               r.end_of_unit = 1'b1;
               step_out.push_back(r);
            end
            field_count = '0;
            nal_remaining = '0;
            phase = PH_PREV;
         end
         foreach (step_out[i])
            es_expected.push_back(step_out[i]);
      endfunction

      function string describe(rsp_payload_type r);
         return $sformatf("byte=%02h kind=%0d time=%08h frame=%0h ch=%0b wide=%0b eou=%0b bad=%0b",
                          r.out_byte, r.unit_kind, r.unit_time, r.frame_kind,
                          r.audio_channels, r.audio_wide, r.end_of_unit, r.bad_header);
      endfunction

      function void check_es_byte(rsp_payload_type got);
         rsp_payload_type want;
         if (es_expected.size() == 0) begin
            fail({"unexpected output ", describe(got)});
            return;
         end
         want = es_expected.pop_front();
         if (got.out_byte !== want.out_byte || got.unit_kind !== want.unit_kind ||
             got.unit_time !== want.unit_time || got.frame_kind !== want.frame_kind ||
             got.audio_channels !== want.audio_channels ||
             got.audio_wide !== want.audio_wide ||
             got.end_of_unit !== want.end_of_unit || got.bad_header !== want.bad_header)
            fail({"expected ", describe(want), " got ", describe(got)});
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   fdab_req_if req_bus ();
   fdab_rsp_if rsp_bus ();

   flv_demux_to_annexb_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   annexb_scoreboard book = new();

   logic [7:0] stream_q[$];
   logic [7:0] body_q[$];
   int         gen_len_size = 4;
   int         cfg_len_next = 4;
   bit         cfg_pending = 1'b0;
   int         gap_left[2] = '{0, 0};
   bit         gap_calm[2] = '{1'b0, 1'b0};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap(int side);
      if (gap_left[side] == 0) begin
         gap_calm[side] = ($urandom_range(0, 3) == 0);
         gap_left[side] = $urandom_range(8, 40);
      end
      gap_left[side]--;
      return gap_calm[side] ? 0 : $urandom_range(0, 8);
   endfunction

   task automatic push_rand(input int n);
      repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic push_len(input int value, input int nbytes);
      for (int i = nbytes - 1; i >= 0; i--)
         body_q.push_back(8'(value >> (8 * i)));
   endtask

   task automatic push_file_header();
      int offset;
      stream_q.push_back(FLV_SIG[23:16]);
      stream_q.push_back(FLV_SIG[15:8]);
      stream_q.push_back(FLV_SIG[7:0]);
      stream_q.push_back(8'h01);
      stream_q.push_back(8'($urandom_range(0, 255)));
      offset = $urandom_range(0, 1) ? $urandom_range(0, 8) : 9 + $urandom_range(1, 3);
      for (int i = 3; i >= 0; i--)
         stream_q.push_back(8'(offset >> (8 * i)));
      for (int i = 9; i < offset; i++)
         stream_q.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic emit_tag(input logic [7:0] kind_b, input logic [31:0] stamp,
                           input int tag_len);
      repeat (4) stream_q.push_back(8'($urandom_range(0, 255)));
      stream_q.push_back(kind_b);
      for (int i = 2; i >= 0; i--)
         stream_q.push_back(8'(tag_len >> (8 * i)));
      stream_q.push_back(stamp[23:16]);
      stream_q.push_back(stamp[15:8]);
      stream_q.push_back(stamp[7:0]);
      stream_q.push_back(stamp[31:24]);
      repeat (3) stream_q.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < tag_len; i++)
         stream_q.push_back(i < body_q.size() ? body_q[i] : 8'($urandom_range(0, 255)));
      // the length-size byte sits at payload offset 9
      if (cfg_pending && tag_len > 9)
         gen_len_size = cfg_len_next;
      cfg_pending = 1'b0;
   endtask

   task automatic avc_config_head(input logic [3:0] fk, input logic [1:0] lsm1,
                                  input int n_sps);
      body_q.delete();
      body_q.push_back({fk, CODEC_AVC});
      body_q.push_back(PKT_CONFIG);
      push_rand(7);
      body_q.push_back({6'($urandom_range(0, 63)), lsm1});
      body_q.push_back({3'($urandom_range(0, 7)), 5'(n_sps)});
      cfg_len_next = int'(lsm1) + 1;
      cfg_pending = 1'b1;
   endtask

   task automatic add_param_set(input int len);
      push_len(len, 2);
      push_rand(len);
   endtask

   task automatic avc_nalu_head(input logic [3:0] fk);
      body_q.delete();
      body_q.push_back({fk, CODEC_AVC});
      body_q.push_back(PKT_NALU);
      push_rand(3);
   endtask

   task automatic add_nal(input int len);
      push_len(len, gen_len_size);
      push_rand(len);
   endtask

   task automatic aac_body(input logic [7:0] pkt, input int len);
      body_q.delete();
      body_q.push_back({FORMAT_AAC, 4'($urandom_range(0, 15))});
      body_q.push_back(pkt);
      push_rand(len);
   endtask

   task automatic push_directed_tags();
      avc_config_head(4'h1, 2'd3, 2);
      add_param_set(3);
      add_param_set(0);
      body_q.push_back(8'd1);
      add_param_set(2);
      push_rand(2);
      emit_tag(TAG_VIDEO, 32'h0000_0000, body_q.size());

      avc_nalu_head(4'h2);
      add_nal(0);
      add_nal(2);
      emit_tag(TAG_VIDEO, 32'hFFFF_FFFF, body_q.size());

      aac_body(8'h00, 2);
      emit_tag(TAG_AUDIO, $urandom(), body_q.size());
      aac_body(8'h01, 3);
      emit_tag(TAG_AUDIO, $urandom(), body_q.size());

      body_q.delete();
      push_rand(3);
      emit_tag(TAG_META, $urandom(), body_q.size());
      emit_tag(TAG_VIDEO, $urandom(), 0);

      // tag ends in the middle of a NAL unit
      avc_nalu_head(4'hF);
      add_nal(4);
      emit_tag(TAG_VIDEO, $urandom(), body_q.size() - 2);
   endtask

   task automatic push_random_tag();
      int pick, n, tag_len;
      logic [7:0] kind_b;
      logic [3:0] code;
      pick = $urandom_range(0, 99);
      kind_b = TAG_VIDEO;
      if (pick < 15) begin
         n = $urandom_range(0, 2);
         avc_config_head(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), n);
         repeat (n) add_param_set($urandom_range(0, 4));
         n = $urandom_range(0, 2);
         body_q.push_back(8'(n));
         repeat (n) add_param_set($urandom_range(0, 4));
         push_rand($urandom_range(0, 2));
      end else if (pick < 50) begin
         avc_nalu_head(4'($urandom_range(0, 15)));
         repeat ($urandom_range(1, 3)) add_nal($urandom_range(0, 5));
      end else if (pick < 75) begin
         kind_b = TAG_AUDIO;
         aac_body(8'($urandom_range(0, 1)), $urandom_range(1, 6));
      end else if (pick < 82) begin
         kind_b = $urandom_range(0, 1) ? TAG_META : 8'($urandom_range(0, 255));
         body_q.delete();
         push_rand($urandom_range(0, 6));
      end else if (pick < 86) begin
         code = 4'($urandom_range(0, 15));
         if (code == CODEC_AVC)
            code = 4'd2;
         body_q.delete();
         body_q.push_back({4'($urandom_range(0, 15)), code});
         push_rand($urandom_range(0, 5));
      end else if (pick < 89) begin
         kind_b = TAG_AUDIO;
         code = 4'($urandom_range(0, 15));
         if (code == FORMAT_AAC)
            code = 4'd2;
         body_q.delete();
         body_q.push_back({code, 4'($urandom_range(0, 15))});
         push_rand($urandom_range(0, 5));
      end else if (pick < 92) begin
         body_q.delete();
         body_q.push_back({4'($urandom_range(0, 15)), CODEC_AVC});
         body_q.push_back(8'($urandom_range(2, 255)));
         push_rand($urandom_range(3, 6));
      end else if (pick < 94) begin
         kind_b = TAG_AUDIO;
         aac_body(8'($urandom_range(2, 255)), $urandom_range(0, 4));
      end else if (pick < 96) begin
         kind_b = $urandom_range(0, 1) ? TAG_AUDIO : TAG_VIDEO;
         body_q.delete();
      end else begin
         avc_nalu_head(4'($urandom_range(0, 15)));
         push_rand($urandom_range(1, 12));
      end
      tag_len = body_q.size();
      pick = $urandom_range(0, 99);
      if (pick < 12 && tag_len > 0)
         tag_len = $urandom_range(0, tag_len - 1);
      else if (pick < 20)
         tag_len += $urandom_range(1, 4);
      emit_tag(kind_b, $urandom(), tag_len);
   endtask

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap(SIDE_SEND);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.payload.in_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      book.note_flv_byte(b);
   endtask

   task automatic send_stream();
      while (stream_q.size() != 0)
         send_byte(stream_q.pop_front());
      req_bus.valid <= 1'b0;
   endtask

   task automatic drain(input int settle);
      int waited;
      waited = 0;
      while (book.es_expected.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {31'h0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      book.set_pass(idx, val);
      // read back through the same port
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[0] !== val)
         book.fail($sformatf("csr %0d read %08h, wrote %0b", idx, csr_prdata, val));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : es_sink
      int gap;
      int taken;
      taken = 0;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         // one long hold-off so the result queue fills and backs up the input
         gap = (taken == 25) ? 120 : pick_gap(SIDE_RECV);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         book.check_es_byte(rsp_bus.payload);
         taken++;
      end
   end

   initial begin : stimulus
      req_bus.valid <= 1'b0;
      req_bus.payload <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      push_file_header();
      push_directed_tags();
      send_stream();

      for (int p = 0; p < 5; p++) begin
         drain(8);
         csr_write(CSR_PASS_AUDIO, AUDIO_PLAN[p]);
         csr_write(CSR_PASS_VIDEO, VIDEO_PLAN[p]);
         while (stream_q.size() < 12) push_random_tag();
         send_stream();
      end

      drain(10);
      if (book.es_expected.size() != 0)
         book.fail($sformatf("%0d expected bytes never came", book.es_expected.size()));
      if (book.errors == 0)
         $display("tb_flv_demux_to_annexb_core: done, clean");
      else
         $display("tb_flv_demux_to_annexb_core: done, errors");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("tb_flv_demux_to_annexb_core: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
